[sv/assert_macros.svh]
// Assertion macros shared by the key/value table RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define AKVT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define AKVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/akvt_pkg.sv]
// Shared types and constants for the key/value table.
// No dependencies; used by every module of the block.
package akvt_pkg;

    localparam int KEY_W       = 31;
    localparam int WORD_W      = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = 2;

    localparam logic [KEY_W-1:0] KEY_FIRST = 31'd1;
    localparam logic [KEY_W-1:0] KEY_LAST  = 31'h7FFF_FFFF;

    typedef enum logic [3:0] {
        OP_ADD         = 4'd0,
        OP_VAL_BY_KEY  = 4'd1,
        OP_KEY_BY_VAL  = 4'd2,
        OP_RM_BY_KEY   = 4'd3,
        OP_RM_BY_VAL   = 4'd4,
        OP_UPDATE_VAL  = 4'd5,
        OP_TAG_BY_KEY  = 4'd6,
        OP_TAG_BY_VAL  = 4'd7,
        OP_GET_TAG     = 4'd8
    } t_op;

    // Classified request as it travels from the front to the back end.
    typedef struct packed {
        t_op               op;
        logic              by_value;
        logic [KEY_W-1:0]  key;
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] tag;
    } t_cmd;

endpackage

[sv/akvt_front.sv]
// Front end: takes requests, classifies them and hands them to the queue.
// Depends on akvt_pkg.
module akvt_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [3:0]                i_op,
    input  logic [akvt_pkg::KEY_W-1:0]  i_key_in,
    input  logic [akvt_pkg::WORD_W-1:0] i_value_in,
    input  logic [akvt_pkg::WORD_W-1:0] i_tag_in,
    input  logic                      i_full,
    output logic                      o_busy,
    output logic                      o_push,
    output akvt_pkg::t_cmd            o_cmd
);

    logic           r_vld;
    akvt_pkg::t_cmd r_cmd;
    akvt_pkg::t_cmd n_cmd;
    logic           w_accept;

    assign o_busy   = r_vld & i_full;
    assign o_push   = r_vld & ~i_full;
    assign o_cmd    = r_cmd;
    assign w_accept = i_start & ~o_busy;

    // Add searches for the empty key; value-based ops compare the value field.
    always_comb begin
        n_cmd          = '0;
        n_cmd.op       = akvt_pkg::t_op'(i_op);
        n_cmd.value    = i_value_in;
        n_cmd.tag      = i_tag_in;
        n_cmd.by_value = n_cmd.op inside {akvt_pkg::OP_KEY_BY_VAL, akvt_pkg::OP_RM_BY_VAL,
                                          akvt_pkg::OP_TAG_BY_VAL};
        n_cmd.key      = (n_cmd.op == akvt_pkg::OP_ADD) ? '0 : i_key_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_accept) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

[sv/akvt_queue.sv]
// Short command queue between the front and back ends.
// Depends on akvt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module akvt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  akvt_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output akvt_pkg::t_cmd o_cmd
);

    akvt_pkg::t_cmd                  r_data [akvt_pkg::QUEUE_DEPTH];
    logic [akvt_pkg::QUEUE_AW-1:0]   r_wp;
    logic [akvt_pkg::QUEUE_AW-1:0]   r_rp;
    logic [akvt_pkg::QUEUE_CW-1:0]   r_cnt;
    logic                            w_push;
    logic                            w_pop;

    assign o_full  = (r_cnt == akvt_pkg::QUEUE_CW'(akvt_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_data[r_rp];
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data[r_wp] <= i_cmd;
        end
    end

    `AKVT_ASSERT_NOW(a_q_no_overflow, i_clk, i_rst_n, i_push, !o_full || i_pop, "queue push while full")
    `AKVT_ASSERT_NEXT(a_q_fill_grows, i_clk, i_rst_n, w_push && !w_pop, r_cnt == $past(r_cnt) + 1'b1, "queue count did not grow on push")

endmodule

[sv/akvt_back.sv]
// Back end: holds the table, scans it one entry per cycle and applies the request.
// Depends on akvt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module akvt_back #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  akvt_pkg::t_cmd              i_cmd,
    output logic                        o_pop,
    output logic                        o_valid,
    output logic                        o_hit,
    output logic signed [akvt_pkg::WORD_W-1:0] o_key_out,
    output logic [akvt_pkg::WORD_W-1:0] o_value_out,
    output logic [akvt_pkg::WORD_W-1:0] o_tag_out
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Table storage; an entry with its valid bit low reads as zero.
    logic [akvt_pkg::KEY_W-1:0]  r_mem_key [TABLE_DEPTH];
    logic [akvt_pkg::WORD_W-1:0] r_mem_val [TABLE_DEPTH];
    logic [akvt_pkg::WORD_W-1:0] r_mem_tag [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]      r_kv_valid;
    logic [TABLE_DEPTH-1:0]      r_tag_valid;

    t_state                      r_state;
    akvt_pkg::t_cmd              r_cmd;
    logic [IW-1:0]               r_idx;
    logic                        r_issue;
    logic                        r_cmp;
    logic [IW-1:0]               r_cidx;
    logic                        r_hit;
    logic [IW-1:0]               r_hidx;
    logic [akvt_pkg::KEY_W-1:0]  r_h_key;
    logic [akvt_pkg::WORD_W-1:0] r_h_val;
    logic [akvt_pkg::WORD_W-1:0] r_h_tag;
    logic [akvt_pkg::KEY_W-1:0]  r_next_key;

    logic [akvt_pkg::KEY_W-1:0]  r_rd_key;
    logic [akvt_pkg::WORD_W-1:0] r_rd_val;
    logic [akvt_pkg::WORD_W-1:0] r_rd_tag;
    logic                        r_rd_kvv;
    logic                        r_rd_tv;

    logic [akvt_pkg::KEY_W-1:0]  w_eff_key;
    logic [akvt_pkg::WORD_W-1:0] w_eff_val;
    logic [akvt_pkg::WORD_W-1:0] w_eff_tag;
    logic                        w_match;
    logic                        w_kv_we;
    logic                        w_kv_clr;
    logic                        w_tag_we;
    logic [akvt_pkg::KEY_W-1:0]  w_wkey;
    logic [akvt_pkg::KEY_W-1:0]  n_next_key;

    assign o_pop     = (r_state == ST_IDLE) & ~i_empty;
    assign w_eff_key = r_rd_kvv ? r_rd_key : '0;
    assign w_eff_val = r_rd_kvv ? r_rd_val : '0;
    assign w_eff_tag = r_rd_tv  ? r_rd_tag : '0;
    assign w_match   = r_cmd.by_value ? (w_eff_val == r_cmd.value) : (w_eff_key == r_cmd.key);
    assign n_next_key = (r_next_key == akvt_pkg::KEY_LAST) ? akvt_pkg::KEY_FIRST
                                                           : r_next_key + 1'b1;

    // Table updates happen in the single result cycle after the scan.
    always_comb begin
        w_kv_we  = 1'b0;
        w_kv_clr = 1'b0;
        w_tag_we = 1'b0;
        w_wkey   = r_h_key;
        if (r_state == ST_DONE && r_hit) begin
            case (r_cmd.op)
                akvt_pkg::OP_ADD: begin
                    w_kv_we = 1'b1;
                    w_wkey  = r_next_key;
                end
                akvt_pkg::OP_UPDATE_VAL: begin
                    w_kv_we = 1'b1;
                end
                akvt_pkg::OP_RM_BY_KEY, akvt_pkg::OP_RM_BY_VAL: begin
                    w_kv_clr = 1'b1;
                end
                akvt_pkg::OP_TAG_BY_KEY, akvt_pkg::OP_TAG_BY_VAL: begin
                    w_tag_we = 1'b1;
                end
                default: begin
                    w_kv_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_kv_we) begin
            r_mem_key[r_hidx] <= w_wkey;
            r_mem_val[r_hidx] <= r_cmd.value;
        end
        if (w_tag_we) begin
            r_mem_tag[r_hidx] <= r_cmd.tag;
        end
        r_rd_key <= r_mem_key[r_idx];
        r_rd_val <= r_mem_val[r_idx];
        r_rd_tag <= r_mem_tag[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_kv_valid  <= '0;
            r_tag_valid <= '0;
            r_next_key  <= akvt_pkg::KEY_FIRST;
            r_issue     <= 1'b0;
            r_cmp       <= 1'b0;
            r_hit       <= 1'b0;
            o_valid     <= 1'b0;
        end else begin
            o_valid  <= 1'b0;
            r_rd_kvv <= r_kv_valid[r_idx];
            r_rd_tv  <= r_tag_valid[r_idx];
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_cmd   <= i_cmd;
                        r_idx   <= '0;
                        r_issue <= 1'b1;
                        r_cmp   <= 1'b0;
                        r_hit   <= 1'b0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_cmp  <= r_issue;
                    r_cidx <= r_idx;
                    if (r_issue) begin
                        if (r_idx == LAST_IDX) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                    if (r_cmp && w_match) begin
                        r_hit   <= 1'b1;
                        r_hidx  <= r_cidx;
                        r_h_key <= w_eff_key;
                        r_h_val <= w_eff_val;
                        r_h_tag <= w_eff_tag;
                        r_state <= ST_DONE;
                    end else if (r_cmp && r_cidx == LAST_IDX) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    o_valid     <= 1'b1;
                    o_hit       <= 1'b0;
                    o_key_out   <= '0;
                    o_value_out <= '0;
                    o_tag_out   <= '0;
                    case (r_cmd.op)
                        akvt_pkg::OP_ADD: begin
                            o_hit     <= r_hit;
                            o_key_out <= r_hit ? {1'b0, r_next_key} : '1;
                        end
                        akvt_pkg::OP_VAL_BY_KEY, akvt_pkg::OP_RM_BY_KEY: begin
                            o_hit       <= r_hit;
                            o_value_out <= r_hit ? r_h_val : '0;
                        end
                        akvt_pkg::OP_KEY_BY_VAL: begin
                            o_hit     <= r_hit;
                            o_key_out <= r_hit ? {1'b0, r_h_key} : '1;
                        end
                        akvt_pkg::OP_RM_BY_VAL: begin
                            o_hit     <= r_hit;
                            o_key_out <= r_hit ? {1'b0, r_h_key} : '0;
                        end
                        akvt_pkg::OP_UPDATE_VAL, akvt_pkg::OP_TAG_BY_KEY,
                        akvt_pkg::OP_TAG_BY_VAL: begin
                            o_hit <= r_hit;
                        end
                        akvt_pkg::OP_GET_TAG: begin
                            o_hit     <= r_hit;
                            o_tag_out <= r_hit ? r_h_tag : '0;
                        end
                        default: begin
                            o_hit <= 1'b0;
                        end
                    endcase
                    if (w_kv_we) begin
                        r_kv_valid[r_hidx] <= 1'b1;
                    end
                    if (w_kv_clr) begin
                        r_kv_valid[r_hidx] <= 1'b0;
                    end
                    if (w_tag_we) begin
                        r_tag_valid[r_hidx] <= 1'b1;
                    end
                    if (w_kv_we && r_cmd.op == akvt_pkg::OP_ADD) begin
                        r_next_key <= n_next_key;
                    end
                    r_issue <= 1'b0;
                    r_cmp   <= 1'b0;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `AKVT_ASSERT_NEXT(a_done_strobes, i_clk, i_rst_n, r_state == ST_DONE, o_valid, "result cycle did not raise the strobe")
    `AKVT_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid, "result strobe held longer than one cycle")
    `AKVT_ASSERT_NOW(a_pop_idle_only, i_clk, i_rst_n, o_pop, r_state == ST_IDLE && !i_empty, "pop outside idle or from empty queue")

endmodule

[sv/associative_key_value_table_top.sv]
// Top level of the associative key/value table.
// Depends on akvt_pkg, akvt_front, akvt_queue and akvt_back.
// Usage:
//   Requests enter on i_op, i_key_in, i_value_in and i_tag_in. A request is
//   taken at a rising edge where start is high and busy is low. Drive start
//   only with a complete request; busy rises when the front register and the
//   command queue are both full.
//   Each request yields exactly one result on o_hit, o_key_out, o_value_out
//   and o_tag_out, shown for one cycle with o_valid high. The receiver cannot
//   hold results off; capture them on the strobe.
//   Scan: the back end scans the table one entry per cycle through a
//   registered read port, stopping at the first match. Each request passes
//   through an idle state, the scan and a result state; the back end takes
//   no new request from the queue until the last one has left the result
//   state. A lone item first passes the front register and the queue;
//   a queued item also waits out the scans ahead of it.
//   The front keeps accepting while the back end scans, up to three items
//   in flight ahead of the scan.
//   Reset (i_rst_n low, synchronous) empties every entry, clears all tags,
//   restarts the key counter at 1 and drops any queued requests. No clearing
//   pass is needed: per-entry valid bits make empty entries read as zero.
module associative_key_value_table_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic [3:0]                          i_op,
    input  logic [akvt_pkg::KEY_W-1:0]          i_key_in,
    input  logic [akvt_pkg::WORD_W-1:0]         i_value_in,
    input  logic [akvt_pkg::WORD_W-1:0]         i_tag_in,
    output logic                                busy,
    output logic                                o_valid,
    output logic                                o_hit,
    output logic signed [akvt_pkg::WORD_W-1:0]  o_key_out,
    output logic [akvt_pkg::WORD_W-1:0]         o_value_out,
    output logic [akvt_pkg::WORD_W-1:0]         o_tag_out
);

    // Front to queue.
    logic           w_push;
    akvt_pkg::t_cmd w_push_cmd;
    logic           w_full;

    // Queue to back end.
    logic           w_pop;
    logic           w_empty;
    akvt_pkg::t_cmd w_pop_cmd;

    // Classify the request and hold it until the queue has room.
    akvt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_op       (i_op),
        .i_key_in   (i_key_in),
        .i_value_in (i_value_in),
        .i_tag_in   (i_tag_in),
        .i_full     (w_full),
        .o_busy     (busy),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    // Decouple intake from the scan so each side stalls on its own.
    akvt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_cmd   (w_pop_cmd)
    );

    // Scan the table, apply the update and drive the result strobe.
    akvt_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_cmd       (w_pop_cmd),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .o_hit       (o_hit),
        .o_key_out   (o_key_out),
        .o_value_out (o_value_out),
        .o_tag_out   (o_tag_out)
    );

endmodule

[sim/tb.sv]
// Testbench for the associative key/value table: directed corner cases, then random requests.
// Depends on akvt_pkg and associative_key_value_table_top; a scoreboard class predicts each result.
// Results are checked in order against a shadow copy of the table.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 250000;
    // Wait after the last result, scaled with the table depth, to catch stray strobes.
    localparam int DRAIN_WAIT  = 3 * (DEPTH + 5);
    localparam int RANDOM_ITEMS = 1400;

    // Codes 9 to 15 are not defined operations.
    localparam logic [3:0] OP_UNDEF_LO = 4'd9;
    localparam logic [3:0] OP_UNDEF_HI = 4'd15;

    // Traffic mixes of the random part.
    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_EVEN  = 2;

    typedef struct packed {
        logic                        hit;
        logic [akvt_pkg::WORD_W-1:0] key;
        logic [akvt_pkg::WORD_W-1:0] value;
        logic [akvt_pkg::WORD_W-1:0] tag;
    } t_lookup_result;

    // Shadow copy of the table and queue of results still owed by the block.
    class kv_table_scoreboard;
        logic [akvt_pkg::KEY_W-1:0]  slot_key[DEPTH];
        logic [akvt_pkg::WORD_W-1:0] slot_value[DEPTH];
        logic [akvt_pkg::WORD_W-1:0] slot_tag[DEPTH];
        logic [akvt_pkg::KEY_W-1:0]  key_counter;
        t_lookup_result              pending_results[$];
        int                          errors;

        function new();
            foreach (slot_key[i]) begin
                slot_key[i]   = '0;
                slot_value[i] = '0;
                slot_tag[i]   = '0;
            end
            key_counter = akvt_pkg::KEY_FIRST;
            errors      = 0;
        endfunction

        // First slot in index order holding key k; empty slots hold key 0.
        function int first_key(logic [akvt_pkg::KEY_W-1:0] k);
            for (int i = 0; i < DEPTH; i++)
                if (slot_key[i] == k) return i;
            return -1;
        endfunction

        function int first_value(logic [akvt_pkg::WORD_W-1:0] v);
            for (int i = 0; i < DEPTH; i++)
                if (slot_value[i] == v) return i;
            return -1;
        endfunction

        function bit table_full();
            return first_key('0) < 0;
        endfunction

        // Apply one accepted request to the shadow table and queue its result.
        function void note_request(logic [3:0] op, logic [akvt_pkg::KEY_W-1:0] key,
                                   logic [akvt_pkg::WORD_W-1:0] value,
                                   logic [akvt_pkg::WORD_W-1:0] tag);
            t_lookup_result res;
            int s;
            res = '0;
            case (op)
                akvt_pkg::OP_ADD: begin
                    s = first_key('0);
                    if (s >= 0) begin
                        slot_key[s]   = key_counter;
                        slot_value[s] = value;
                        res.hit       = 1'b1;
                        res.key       = {1'b0, key_counter};
                        key_counter   = (key_counter == akvt_pkg::KEY_LAST)
                                        ? akvt_pkg::KEY_FIRST : key_counter + 1'b1;
                    end else begin
                        res.key = '1;
                    end
                end
                akvt_pkg::OP_VAL_BY_KEY: begin
                    s = first_key(key);
                    if (s >= 0) begin
                        res.hit   = 1'b1;
                        res.value = slot_value[s];
                    end
                end
                akvt_pkg::OP_KEY_BY_VAL: begin
                    s = first_value(value);
                    if (s >= 0) begin
                        res.hit = 1'b1;
                        res.key = {1'b0, slot_key[s]};
                    end else begin
                        res.key = '1;
                    end
                end
                akvt_pkg::OP_RM_BY_KEY: begin
                    s = first_key(key);
                    if (s >= 0) begin
                        res.hit       = 1'b1;
                        res.value     = slot_value[s];
                        slot_key[s]   = '0;
                        slot_value[s] = '0;
                    end
                end
                akvt_pkg::OP_RM_BY_VAL: begin
                    s = first_value(value);
                    if (s >= 0) begin
                        res.hit       = 1'b1;
                        res.key       = {1'b0, slot_key[s]};
                        slot_key[s]   = '0;
                        slot_value[s] = '0;
                    end
                end
                akvt_pkg::OP_UPDATE_VAL: begin
                    s = first_key(key);
                    if (s >= 0) begin
                        res.hit       = 1'b1;
                        slot_value[s] = value;
                    end
                end
                akvt_pkg::OP_TAG_BY_KEY: begin
                    s = first_key(key);
                    if (s >= 0) begin
                        res.hit     = 1'b1;
                        slot_tag[s] = tag;
                    end
                end
                akvt_pkg::OP_TAG_BY_VAL: begin
                    s = first_value(value);
                    if (s >= 0) begin
                        res.hit     = 1'b1;
                        slot_tag[s] = tag;
                    end
                end
                akvt_pkg::OP_GET_TAG: begin
                    s = first_key(key);
                    if (s >= 0) begin
                        res.hit = 1'b1;
                        res.tag = slot_tag[s];
                    end
                end
                default: ;
            endcase
            pending_results.push_back(res);
        endfunction

        task flag_mismatch(string what, logic [akvt_pkg::WORD_W-1:0] exp_val,
                           logic [akvt_pkg::WORD_W-1:0] got_val);
            $display("mismatch in %s: expected %h, got %h", what, exp_val, got_val);
            errors++;
        endtask

        // Compare one strobed result with the oldest outstanding one.
        task check_result(logic hit, logic [akvt_pkg::WORD_W-1:0] key,
                          logic [akvt_pkg::WORD_W-1:0] value,
                          logic [akvt_pkg::WORD_W-1:0] tag);
            t_lookup_result exp_res;
            if (pending_results.size() == 0) begin
                flag_mismatch("result strobe with nothing outstanding", '0, {31'd0, hit});
            end else begin
                exp_res = pending_results.pop_front();
                if (hit !== exp_res.hit)
                    flag_mismatch("hit", {31'd0, exp_res.hit}, {31'd0, hit});
                if (key !== exp_res.key)     flag_mismatch("key_out", exp_res.key, key);
                if (value !== exp_res.value) flag_mismatch("value_out", exp_res.value, value);
                if (tag !== exp_res.tag)     flag_mismatch("tag_out", exp_res.tag, tag);
            end
        endtask
    endclass

    // All inputs start at known values; reset is held low from time zero.
    logic                               i_clk      = 1'b0;
    logic                               i_rst_n    = 1'b0;
    logic                               start      = 1'b0;
    logic [3:0]                         i_op       = '0;
    logic [akvt_pkg::KEY_W-1:0]         i_key_in   = '0;
    logic [akvt_pkg::WORD_W-1:0]        i_value_in = '0;
    logic [akvt_pkg::WORD_W-1:0]        i_tag_in   = '0;
    logic                               busy;
    logic                               o_valid;
    logic                               o_hit;
    logic signed [akvt_pkg::WORD_W-1:0] o_key_out;
    logic [akvt_pkg::WORD_W-1:0]        o_value_out;
    logic [akvt_pkg::WORD_W-1:0]        o_tag_out;

    kv_table_scoreboard sb;
    int cycle_count = 0;

    associative_key_value_table_top #(
        .TABLE_DEPTH(DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_op       (i_op),
        .i_key_in   (i_key_in),
        .i_value_in (i_value_in),
        .i_tag_in   (i_tag_in),
        .busy       (busy),
        .o_valid    (o_valid),
        .o_hit      (o_hit),
        .o_key_out  (o_key_out),
        .o_value_out(o_value_out),
        .o_tag_out  (o_tag_out)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Watchdog: end the run if the block stops answering.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // The strobe lasts one cycle and cannot be held off: capture on every edge it is high.
    // Outputs read here are the values from before the edge, so there is no race with the RTL.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result(o_hit, o_key_out, o_value_out, o_tag_out);
    end

    // Present one request and hold it until an edge sees start high with busy low.
    // Leave start high on return: the caller either drives the next item in this
    // same time step or drops start through idle_for.
    task automatic send_request(logic [3:0] op, logic [akvt_pkg::KEY_W-1:0] key,
                                logic [akvt_pkg::WORD_W-1:0] value,
                                logic [akvt_pkg::WORD_W-1:0] tag);
        i_op       <= op;
        i_key_in   <= key;
        i_value_in <= value;
        i_tag_in   <= tag;
        start      <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(op, key, value, tag);
    endtask

    task automatic idle_for(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Mostly live keys so lookups hit; also key 0, recently issued keys and wide random ones.
    function automatic logic [akvt_pkg::KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return sb.slot_key[$urandom_range(0, DEPTH - 1)];
        if (r < 75) return '0;
        if (r < 88) return akvt_pkg::KEY_W'($urandom());
        return sb.key_counter - akvt_pkg::KEY_W'($urandom_range(1, 20));
    endfunction

    // Values drawn from live entries and a small pool collide often; the rest cover all bits.
    function automatic logic [akvt_pkg::WORD_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return sb.slot_value[$urandom_range(0, DEPTH - 1)];
        if (r < 55) return '0;
        if (r < 80) return akvt_pkg::WORD_W'($urandom_range(0, 7));
        return $urandom();
    endfunction

    // Weight adds against removals so the table swings between empty and full.
    function automatic logic [3:0] pick_op(int mix);
        int r;
        int add_pct;
        int rm_pct;
        r       = $urandom_range(0, 99);
        add_pct = (mix == MIX_FILL) ? 45 : (mix == MIX_DRAIN) ? 8 : 22;
        rm_pct  = (mix == MIX_DRAIN) ? 35 : (mix == MIX_FILL) ? 8 : 18;
        if (r < add_pct) return akvt_pkg::OP_ADD;
        if (r < add_pct + rm_pct)
            return ($urandom_range(0, 1) != 0) ? akvt_pkg::OP_RM_BY_KEY : akvt_pkg::OP_RM_BY_VAL;
        if (r >= 97) return 4'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        case ($urandom_range(0, 5))
            0:       return akvt_pkg::OP_VAL_BY_KEY;
            1:       return akvt_pkg::OP_KEY_BY_VAL;
            2:       return akvt_pkg::OP_UPDATE_VAL;
            3:       return akvt_pkg::OP_TAG_BY_KEY;
            4:       return akvt_pkg::OP_TAG_BY_VAL;
            default: return akvt_pkg::OP_GET_TAG;
        endcase
    endfunction

    initial begin
        int burst_left;
        int phase_left;
        int mix;
        logic [3:0] op;

        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed part.
        // Searches on an empty table: key 0 matches slot 0 for a value and a tag lookup.
        send_request(akvt_pkg::OP_VAL_BY_KEY, '0, '0, '0);
        send_request(akvt_pkg::OP_GET_TAG, '0, '1, '1);
        send_request(akvt_pkg::OP_ADD, '1, '1, '1);
        send_request(akvt_pkg::OP_ADD, '0, '0, '0);
        send_request(akvt_pkg::OP_ADD, '0, 32'h8000_0001, '0);
        // Value 0 now matches the live entry in slot 1 before any empty slot.
        send_request(akvt_pkg::OP_KEY_BY_VAL, '0, '0, '0);
        send_request(akvt_pkg::OP_KEY_BY_VAL, '0, 32'h5A5A_5A5A, '0);
        send_request(akvt_pkg::OP_TAG_BY_KEY, akvt_pkg::KEY_W'(1), '0, '1);
        send_request(akvt_pkg::OP_GET_TAG, akvt_pkg::KEY_W'(1), '0, '0);
        send_request(akvt_pkg::OP_TAG_BY_VAL, '0, 32'h8000_0001, 32'h1234_5678);
        send_request(akvt_pkg::OP_UPDATE_VAL, akvt_pkg::KEY_W'(3), 32'hCAFE_F00D, '0);
        send_request(akvt_pkg::OP_TAG_BY_KEY, akvt_pkg::KEY_W'(2), '0, 32'h0BAD_BEEF);
        idle_for(3);
        // Removal clears key and value but keeps the tag; a key-0 search then sees it.
        send_request(akvt_pkg::OP_RM_BY_KEY, akvt_pkg::KEY_W'(2), '0, '0);
        send_request(akvt_pkg::OP_GET_TAG, '0, '0, '0);
        // Remove and update that land on an empty slot.
        send_request(akvt_pkg::OP_RM_BY_VAL, '0, '0, '0);
        send_request(akvt_pkg::OP_UPDATE_VAL, '0, 32'd77, '0);
        send_request(akvt_pkg::OP_KEY_BY_VAL, '0, 32'd77, '0);
        // Misses on every keyed and valued write.
        send_request(akvt_pkg::OP_RM_BY_KEY, '1, '1, '1);
        send_request(akvt_pkg::OP_UPDATE_VAL, akvt_pkg::KEY_W'(31'h4000_0000), '1, '0);
        send_request(akvt_pkg::OP_TAG_BY_KEY, akvt_pkg::KEY_W'(31'h2AAA_AAAA), '0, '1);
        send_request(akvt_pkg::OP_TAG_BY_VAL, '0, 32'h5555_5555, '1);
        send_request(akvt_pkg::OP_RM_BY_VAL, '0, 32'hFFFF_FFFE, '0);
        // Undefined codes at both ends of their range.
        send_request(OP_UNDEF_LO, '1, '1, '1);
        send_request(OP_UNDEF_HI, '1, '1, '1);
        // Fill the table, then add once more to a full table.
        while (!sb.table_full())
            send_request(akvt_pkg::OP_ADD, '0, $urandom(), '0);
        send_request(akvt_pkg::OP_ADD, '0, 32'hDEAD_0001, '0);
        send_request(akvt_pkg::OP_KEY_BY_VAL, '0, '0, '0);
        idle_for(5);

        // Random part: phases with their own mix, bursts of random length between gaps.
        burst_left = 0;
        phase_left = 0;
        mix        = MIX_EVEN;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 80);
                mix        = $urandom_range(MIX_FILL, MIX_EVEN);
            end
            phase_left--;
            op = pick_op(mix);
            send_request(op, pick_key(), pick_value(), $urandom());
            if (burst_left == 0) begin
                // Long back-to-back bursts now and then, otherwise short ones.
                burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                          : $urandom_range(1, 12);
                idle_for($urandom_range(1, 2 * DEPTH + 6));
            end else begin
                burst_left--;
            end
        end
        idle_for(0);

        // Drain: wait for every outstanding result, then watch for stray strobes.
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[associative_key_value_table_top.f]
+incdir+sv
sv/akvt_pkg.sv
sv/akvt_front.sv
sv/akvt_queue.sv
sv/akvt_back.sv
sv/associative_key_value_table_top.sv
sim/tb.sv
